FILE: rtl/core/ssh_pkg.sv
package ssh_pkg;

    // table geometry
    localparam int MAX_ENTRIES = 64;
    localparam int KEY_BITS    = 32;
    localparam int COUNT_BITS  = 32;
    localparam int MAX_RESULTS = 64;

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
    localparam int RES_W  = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
    localparam int PROD_W = 17 + 32;
    localparam int THR_W  = (COUNT_BITS + 16 > PROD_W) ? COUNT_BITS + 16 : PROD_W;

    // opcodes
    localparam logic [1:0] OP_UPDATE   = 2'd0;
    localparam logic [1:0] OP_FREQUENT = 2'd1;
    localparam logic [1:0] OP_TOPK     = 2'd2;

    // one monitored entry
    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] count;
        logic [COUNT_BITS-1:0] error;
    } entry_t;

    // read-out stage of a cell, shifted toward cell 0 during a query
    typedef struct packed {
        entry_t ent;
        logic   qual;
    } readout_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                  move;
        logic                  load_rd;
        logic                  shift_rd;
        logic                  frequent;
        logic [6:0]            top_count;
        logic [THR_W-1:0]      threshold;
        logic [IDX_W-1:0]      p_idx;
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] upd_count;
        logic [COUNT_BITS-1:0] new_error;
    } cell_ctrl_t;

    // saturating increment
    function automatic logic [COUNT_BITS-1:0] count_inc(input logic [COUNT_BITS-1:0] c);
        logic [COUNT_BITS-1:0] r;
        r = (c == {COUNT_BITS{1'b1}}) ? c : c + 1'b1;
        return r;
    endfunction

endpackage

FILE: rtl/core/space_saving_heavy_hitter_table.sv
// channel | handshake          | payload
// in      | in_valid, in_stall | opcode, item_key, query_fraction, top_count
// out     | out_valid, out_stall | entry_valid, entry_key, entry_count,
//         |                    | entry_error, total_items, last_result
//
// update: accept, key search over the cell row, source select and increment,
//   then shift of the row
// query: threshold product, then load of the read-out chain, then one result
//   per cycle while the output is not stalled, as the chain shifts toward cell 0
// reset clears the sequencer, occupancy and total; no clearing pass
// a stalled output holds the read-out chain; input stalls until idle
module space_saving_heavy_hitter_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] item_key,
    input  logic [16:0] query_fraction,
    input  logic [6:0]  top_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        entry_valid,
    output logic [31:0] entry_key,
    output logic [31:0] entry_count,
    output logic [31:0] entry_error,
    output logic [31:0] total_items,
    output logic        last_result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMPUTE,
        ST_MOVE,
        ST_QPROD,
        ST_QLOAD,
        ST_QEMIT
    } state_t;

    state_t                                 state_reg, state_next;
    logic                                   freq_reg, freq_next;
    logic [ssh_pkg::KEY_BITS-1:0]           key_reg, key_next;
    logic [16:0]                            frac_reg, frac_next;
    logic [6:0]                             topk_reg, topk_next;
    logic [ssh_pkg::OCC_W-1:0]              occ_reg, occ_next;
    logic [31:0]                            total_reg, total_next;
    logic [ssh_pkg::MAX_ENTRIES-1:0]        hit_vec_reg, hit_vec_next;
    logic [ssh_pkg::MAX_ENTRIES-1:0]        cand_vec_reg, cand_vec_next;
    logic [ssh_pkg::IDX_W-1:0]              p_reg, p_next;
    logic [ssh_pkg::COUNT_BITS-1:0]         newc_reg, newc_next;
    logic [ssh_pkg::COUNT_BITS-1:0]         newe_reg, newe_next;
    logic [ssh_pkg::THR_W-1:0]              thr_reg, thr_next;
    logic [ssh_pkg::RES_W-1:0]              emit_cnt_reg, emit_cnt_next;
    logic                                   out_valid_reg, out_valid_next;
    logic                                   out_ev_reg, out_ev_next;
    logic [31:0]                            out_key_reg, out_key_next;
    logic [31:0]                            out_count_reg, out_count_next;
    logic [31:0]                            out_error_reg, out_error_next;
    logic [31:0]                            out_total_reg, out_total_next;
    logic                                   out_last_reg, out_last_next;

    ssh_pkg::cell_ctrl_t                    ctrl;
    ssh_pkg::entry_t                        ent_chain [ssh_pkg::MAX_ENTRIES];
    ssh_pkg::readout_t                      rd_chain  [ssh_pkg::MAX_ENTRIES+1];
    logic [ssh_pkg::MAX_ENTRIES:0]          inr_chain;
    logic [ssh_pkg::MAX_ENTRIES-1:0]        hit_vec;
    logic [ssh_pkg::MAX_ENTRIES-1:0]        cand_vec;
    logic [ssh_pkg::COUNT_BITS-1:0]         last_count;

    logic                                   in_take;
    logic                                   out_free;
    logic                                   hit_any;
    logic [ssh_pkg::MAX_ENTRIES-1:0]        src_vec;
    logic [ssh_pkg::IDX_W-1:0]              src_idx;
    logic [ssh_pkg::COUNT_BITS-1:0]         src_count;
    logic [ssh_pkg::COUNT_BITS-1:0]         src_error;
    logic [ssh_pkg::PROD_W-1:0]             prod;
    logic                                   res_last;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // broadcast control to the cell row
    always_comb
    begin
        ctrl           = '0;
        ctrl.move      = (state_reg == ST_MOVE);
        ctrl.load_rd   = (state_reg == ST_QLOAD);
        ctrl.shift_rd  = (state_reg == ST_QEMIT) && out_free;
        ctrl.frequent  = freq_reg;
        ctrl.top_count = topk_reg;
        ctrl.threshold = thr_reg;
        ctrl.p_idx     = p_reg;
        ctrl.key       = key_reg;
        ctrl.upd_count = newc_reg;
        ctrl.new_error = newe_reg;
    end

    assign last_count  = ent_chain[ssh_pkg::MAX_ENTRIES-1].count;
    assign inr_chain[0] = 1'b0;
    assign rd_chain[ssh_pkg::MAX_ENTRIES] = '0;

    // row of cells, ordered by count, highest at cell 0
    for (genvar i = 0; i < ssh_pkg::MAX_ENTRIES; i++)
    begin : g_cell
        ssh_pkg::entry_t left_ent;
        if (i == 0)
        begin : g_head
            assign left_ent = '0;
        end
        else
        begin : g_body
            assign left_ent = ent_chain[i-1];
        end

        ssh_cell u_cell (
            .clk        (clk),
            .idx        ((ssh_pkg::IDX_W)'(i)),
            .occ        (occ_reg),
            .ctrl       (ctrl),
            .left_ent   (left_ent),
            .left_inr   (inr_chain[i]),
            .right_rd   (rd_chain[i+1]),
            .last_count (last_count),
            .ent        (ent_chain[i]),
            .inr        (inr_chain[i+1]),
            .hit        (hit_vec[i]),
            .cand       (cand_vec[i]),
            .rd         (rd_chain[i])
        );
    end

    // source slot: matching key, else start of the least-count run
    assign hit_any = |hit_vec_reg;
    assign src_vec = hit_any ? hit_vec_reg : cand_vec_reg;

    always_comb
    begin
        src_idx   = '0;
        src_count = '0;
        src_error = '0;
        for (int i = 0; i < ssh_pkg::MAX_ENTRIES; i++)
        begin
            if (src_vec[i])
            begin
                src_idx   = src_idx | (ssh_pkg::IDX_W)'(i);
                src_count = src_count | ent_chain[i].count;
                src_error = src_error | ent_chain[i].error;
            end
        end
    end

    // fraction times total for the frequent threshold
    assign prod = (ssh_pkg::PROD_W)'(frac_reg) * (ssh_pkg::PROD_W)'(total_reg);

    // last result when the next read-out stage does not qualify or the cap is hit
    assign res_last = !rd_chain[1].qual
                      || (emit_cnt_reg == (ssh_pkg::RES_W)'(ssh_pkg::MAX_RESULTS - 1));

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        freq_next      = freq_reg;
        key_next       = key_reg;
        frac_next      = frac_reg;
        topk_next      = topk_reg;
        occ_next       = occ_reg;
        total_next     = total_reg;
        hit_vec_next   = hit_vec_reg;
        cand_vec_next  = cand_vec_reg;
        p_next         = p_reg;
        newc_next      = newc_reg;
        newe_next      = newe_reg;
        thr_next       = thr_reg;
        emit_cnt_next  = emit_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_ev_next    = out_ev_reg;
        out_key_next   = out_key_reg;
        out_count_next = out_count_reg;
        out_error_next = out_error_reg;
        out_total_next = out_total_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    key_next  = (ssh_pkg::KEY_BITS)'(item_key);
                    frac_next = query_fraction;
                    topk_next = top_count;
                    freq_next = (opcode == ssh_pkg::OP_FREQUENT);
                    if (opcode == ssh_pkg::OP_UPDATE)
                    begin
                        total_next = (total_reg == 32'hFFFF_FFFF) ? total_reg
                                                                  : total_reg + 32'd1;
                        state_next = ST_SEARCH;
                    end
                    else if ((opcode == ssh_pkg::OP_FREQUENT)
                             || (opcode == ssh_pkg::OP_TOPK))
                    begin
                        state_next = ST_QPROD;
                    end
                end
            end
            ST_SEARCH:
            begin
                hit_vec_next  = hit_vec;
                cand_vec_next = cand_vec;
                state_next    = ST_COMPUTE;
            end
            ST_COMPUTE:
            begin
                if (hit_any)
                begin
                    p_next    = src_idx;
                    newc_next = ssh_pkg::count_inc(src_count);
                    newe_next = src_error;
                end
                else if (occ_reg < (ssh_pkg::OCC_W)'(ssh_pkg::MAX_ENTRIES))
                begin
                    p_next    = (ssh_pkg::IDX_W)'(occ_reg);
                    newc_next = (ssh_pkg::COUNT_BITS)'(1);
                    newe_next = '0;
                    occ_next  = occ_reg + 1'b1;
                end
                else
                begin
                    p_next    = src_idx;
                    newc_next = ssh_pkg::count_inc(src_count);
                    newe_next = src_count;
                end
                state_next = ST_MOVE;
            end
            ST_MOVE:
            begin
                state_next = ST_IDLE;
            end
            ST_QPROD:
            begin
                thr_next   = (ssh_pkg::THR_W)'(prod);
                state_next = ST_QLOAD;
            end
            ST_QLOAD:
            begin
                emit_cnt_next = '0;
                state_next    = ST_QEMIT;
            end
            ST_QEMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_total_next = total_reg;
                    emit_cnt_next  = emit_cnt_reg + 1'b1;
                    if (rd_chain[0].qual)
                    begin
                        out_ev_next    = 1'b1;
                        out_key_next   = 32'(rd_chain[0].ent.key);
                        out_count_next = 32'(rd_chain[0].ent.count);
                        out_error_next = 32'(rd_chain[0].ent.error);
                        out_last_next  = res_last;
                        if (res_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        // empty answer
                        out_ev_next    = 1'b0;
                        out_key_next   = '0;
                        out_count_next = '0;
                        out_error_next = '0;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // transaction payload and working registers
    always_ff @(posedge clk)
    begin
        freq_reg      <= freq_next;
        key_reg       <= key_next;
        frac_reg      <= frac_next;
        topk_reg      <= topk_next;
        hit_vec_reg   <= hit_vec_next;
        cand_vec_reg  <= cand_vec_next;
        p_reg         <= p_next;
        newc_reg      <= newc_next;
        newe_reg      <= newe_next;
        thr_reg       <= thr_next;
        emit_cnt_reg  <= emit_cnt_next;
        out_ev_reg    <= out_ev_next;
        out_key_reg   <= out_key_next;
        out_count_reg <= out_count_next;
        out_error_reg <= out_error_next;
        out_total_reg <= out_total_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign entry_valid = out_ev_reg;
    assign entry_key   = out_key_reg;
    assign entry_count = out_count_reg;
    assign entry_error = out_error_reg;
    assign total_items = out_total_reg;
    assign last_result = out_last_reg;

    // keys in the table are unique, so at most one slot matches
    a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMPUTE) |-> $onehot0(hit_vec_reg))
        else $error("more than one slot matched the key");

    // a full table always has exactly one start of the least-count run
    a_cand_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_COMPUTE)
         && (occ_reg == (ssh_pkg::OCC_W)'(ssh_pkg::MAX_ENTRIES)))
        |-> $onehot(cand_vec_reg))
        else $error("replacement candidate not unique");

    // occupancy never passes the table size
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= (ssh_pkg::OCC_W)'(ssh_pkg::MAX_ENTRIES))
        else $error("occupancy beyond table size");

    // an empty answer is always the final result
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ev_reg) |-> out_last_reg)
        else $error("empty answer not marked last");

endmodule

FILE: rtl/core/ssh_cell.sv
module ssh_cell (
    input  logic                                clk,
    input  logic [ssh_pkg::IDX_W-1:0]           idx,
    input  logic [ssh_pkg::OCC_W-1:0]           occ,
    input  ssh_pkg::cell_ctrl_t                 ctrl,
    input  ssh_pkg::entry_t                     left_ent,
    input  logic                                left_inr,
    input  ssh_pkg::readout_t                   right_rd,
    input  logic [ssh_pkg::COUNT_BITS-1:0]      last_count,
    output ssh_pkg::entry_t                     ent,
    output logic                                inr,
    output logic                                hit,
    output logic                                cand,
    output ssh_pkg::readout_t                   rd
);

    ssh_pkg::entry_t   ent_reg;
    ssh_pkg::entry_t   ent_next;
    ssh_pkg::readout_t rd_reg;
    ssh_pkg::readout_t rd_next;
    logic              occupied;
    logic              lt;
    logic              thr_ok;
    logic              qual;

    // slot lies inside the filled part of the table
    assign occupied = ((ssh_pkg::OCC_W)'(idx) < occ);

    // search flags: key match and start of the run of least count
    assign hit  = occupied && (ent_reg.key == ctrl.key);
    assign cand = occupied && (ent_reg.count == last_count)
                  && !((idx != '0) && (left_ent.count == last_count));

    // slot takes part in the reordering window [insert point, source]
    assign lt  = (ent_reg.count < ctrl.upd_count);
    assign inr = (lt && (idx < ctrl.p_idx)) || (idx == ctrl.p_idx);

    // query qualification
    assign thr_ok = ((ssh_pkg::THR_W)'({ent_reg.count, 16'b0}) >= ctrl.threshold);
    assign qual   = occupied && (ctrl.frequent ? thr_ok
                                               : (32'(idx) < 32'(ctrl.top_count)));

    // entry update: shift from left neighbor or take the changed entry
    always_comb
    begin
        ent_next = ent_reg;
        if (ctrl.move && inr)
        begin
            if (left_inr)
            begin
                ent_next = left_ent;
            end
            else
            begin
                ent_next.key   = ctrl.key;
                ent_next.count = ctrl.upd_count;
                ent_next.error = ctrl.new_error;
            end
        end
    end

    // read-out stage: load own entry, then shift toward the head
    always_comb
    begin
        rd_next = rd_reg;
        if (ctrl.load_rd)
        begin
            rd_next.ent  = ent_reg;
            rd_next.qual = qual;
        end
        else if (ctrl.shift_rd)
        begin
            rd_next = right_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        rd_reg  <= rd_next;
    end

    assign ent = ent_reg;
    assign rd  = rd_reg;

endmodule
